/* sv/ctsw_pkg.sv */
// ----------------------------------------------------------------------------
// Countdown timer and stopwatch package
// Shared types, constants and register indexes for the timer block.
// ----------------------------------------------------------------------------
package ctsw_pkg;

  localparam int unsigned MIN_W  = 7;
  localparam int unsigned SEC_W  = 6;
  localparam int unsigned HUN_W  = 7;
  localparam int unsigned PRE_W  = 7;
  localparam int unsigned HOLD_W = 10;
  localparam int unsigned REP_W  = 8;
  localparam int unsigned CFG_W  = 10;

  localparam logic [MIN_W-1:0]  SET_LIMIT     = MIN_W'(59);
  localparam logic [SEC_W-1:0]  SEC_LIMIT     = SEC_W'(59);
  localparam logic [SEC_W-1:0]  SEC_WRAP      = SEC_W'(60);
  localparam logic [MIN_W-1:0]  MIN_WRAP      = MIN_W'(100);
  localparam logic [HUN_W-1:0]  HUN_WRAP      = HUN_W'(100);
  localparam logic [PRE_W-1:0]  TICKS_PER_SEC = PRE_W'(100);
  localparam logic [HOLD_W-1:0] HOLD_MAX      = HOLD_W'(1023);
  localparam logic [REP_W-1:0]  REPEAT_RESET  = REP_W'(20);
  localparam logic [HOLD_W-1:0] LONG_RESET    = HOLD_W'(200);

  typedef enum logic [2:0] {
    PAT_NONE  = 3'b000,
    PAT_ONE   = 3'b001,
    PAT_TWO   = 3'b010,
    PAT_THREE = 3'b100
  } pat_code_t;

  typedef enum logic {
    MODE_TIMER     = 1'b0,
    MODE_STOPWATCH = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    CFG_MODE   = 2'd0,
    CFG_REPEAT = 2'd1,
    CFG_LONG   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    mode_t              mode;
    logic [REP_W-1:0]   repeat_ticks;
    logic [HOLD_W-1:0]  long_press_ticks;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] pat;
  } btn_item_t;

endpackage

/* sv/ctsw_in_stage.sv */
// ----------------------------------------------------------------------------
// Timer input stage
// Registers one button item and holds it until the update stage takes it.
// ----------------------------------------------------------------------------
module ctsw_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_button_one,
  input  logic                in_button_two,
  input  logic                in_button_three,
  input  logic                take,
  output ctsw_pkg::btn_item_t item
);
  import ctsw_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  logic [2:0] pat_r;
  logic       load;

  assign in_stall = valid_r & ~take;
  assign load     = in_valid & ~in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pat_r <= {in_button_three, in_button_two, in_button_one};
    end
  end

  assign item.valid = valid_r;
  assign item.pat   = pat_r;

endmodule

/* sv/ctsw_core.sv */
// ----------------------------------------------------------------------------
// Timer update stage
// Applies one tick to the timer state and registers the resulting item.
// ----------------------------------------------------------------------------
module ctsw_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctsw_pkg::cfg_t        cfg,
  input  ctsw_pkg::btn_item_t   item,
  output logic                  take,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ctsw_pkg::MIN_W-1:0] out_minutes,
  output logic [ctsw_pkg::SEC_W-1:0] out_seconds,
  output logic [ctsw_pkg::HUN_W-1:0] out_hundredths,
  output logic                  out_running,
  output logic                  out_alarm,
  output logic                  out_led
);
  import ctsw_pkg::*;

  logic [MIN_W-1:0]  min_r,   min_nxt;
  logic [SEC_W-1:0]  sec_r,   sec_nxt;
  logic [HUN_W-1:0]  hun_r,   hun_nxt;
  logic [PRE_W-1:0]  pre_r,   pre_nxt;
  logic              run_r,   run_nxt;
  logic              alarm_r, alarm_nxt;
  logic              led_r,   led_nxt;
  logic [HOLD_W-1:0] hold_r,  hold_nxt;
  logic [REP_W-1:0]  rep_r,   rep_nxt;
  logic [2:0]        last_r,  last_nxt;

  logic              ovalid_r, ovalid_nxt;
  logic [MIN_W-1:0]  omin_r;
  logic [SEC_W-1:0]  osec_r;
  logic [HUN_W-1:0]  ohun_r;
  logic              orun_r, oalarm_r, oled_r;

  logic [2:0]        pat;
  logic              step;
  logic [REP_W:0]    rep_inc;
  logic [PRE_W-1:0]  pre_inc;
  logic [HUN_W-1:0]  hun_inc;
  logic [SEC_W-1:0]  sec_inc;
  logic [MIN_W-1:0]  min_inc;

  assign pat     = item.pat;
  assign take    = item.valid & (~ovalid_r | ~out_stall);
  assign rep_inc = {1'b0, rep_r} + (REP_W+1)'(1);

  always_comb begin
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    hun_nxt   = hun_r;
    pre_nxt   = pre_r;
    run_nxt   = run_r;
    alarm_nxt = alarm_r;
    led_nxt   = led_r;
    hold_nxt  = hold_r;
    rep_nxt   = rep_r;
    step      = 1'b0;
    pre_inc   = '0;
    hun_inc   = '0;
    sec_inc   = '0;
    min_inc   = '0;

    unique case (cfg.mode)
      MODE_TIMER: begin
        if ((pat == PAT_ONE || pat == PAT_TWO) && !run_r) begin
          alarm_nxt = 1'b0;
          if (last_r != pat) begin
            step    = 1'b1;
            rep_nxt = '0;
          end else if (rep_inc >= {1'b0, cfg.repeat_ticks}) begin
            step    = 1'b1;
            rep_nxt = '0;
          end else begin
            rep_nxt = rep_inc[REP_W-1:0];
          end
        end else begin
          rep_nxt = '0;
        end

        if (step) begin
          if (pat == PAT_ONE) begin
            if (min_r < SET_LIMIT) begin
              min_nxt = min_r + MIN_W'(1);
            end
          end else if (sec_r < SEC_LIMIT) begin
            sec_nxt = sec_r + SEC_W'(1);
          end
        end

        if (pat == PAT_THREE) begin
          if (hold_r != HOLD_MAX) begin
            hold_nxt = hold_r + HOLD_W'(1);
          end
        end else begin
          hold_nxt = '0;
          if (last_r == PAT_THREE) begin
            if (hold_r >= cfg.long_press_ticks) begin
              min_nxt   = '0;
              sec_nxt   = '0;
              alarm_nxt = 1'b0;
              run_nxt   = 1'b0;
            end else if (run_r) begin
              run_nxt = 1'b0;
            end else if (min_nxt != '0 || sec_nxt != '0) begin
              run_nxt   = 1'b1;
              alarm_nxt = 1'b0;
              pre_nxt   = '0;
              led_nxt   = 1'b0;
            end
          end
        end

        if (run_nxt) begin
          pre_inc = pre_nxt + PRE_W'(1);
          pre_nxt = pre_inc;
          if (pre_inc >= TICKS_PER_SEC) begin
            pre_nxt = '0;
            led_nxt = ~led_nxt;
            if (sec_nxt != '0) begin
              sec_nxt = sec_nxt - SEC_W'(1);
            end else if (min_nxt != '0) begin
              min_nxt = min_nxt - MIN_W'(1);
              sec_nxt = SEC_LIMIT;
            end
            if (min_nxt == '0 && sec_nxt == '0) begin
              alarm_nxt = 1'b1;
              run_nxt   = 1'b0;
            end
          end
        end
      end

      MODE_STOPWATCH: begin
        rep_nxt  = '0;
        hold_nxt = '0;
        if (pat == PAT_ONE && last_r != PAT_ONE) begin
          run_nxt = ~run_r;
        end else if (pat == PAT_TWO) begin
          run_nxt = 1'b0;
          min_nxt = '0;
          sec_nxt = '0;
          hun_nxt = '0;
        end
        if (run_nxt) begin
          led_nxt = 1'b1;
          hun_inc = hun_nxt + HUN_W'(1);
          hun_nxt = hun_inc;
          if (hun_inc >= HUN_WRAP) begin
            hun_nxt = '0;
            sec_inc = sec_nxt + SEC_W'(1);
            sec_nxt = sec_inc;
            if (sec_inc >= SEC_WRAP) begin
              sec_nxt = '0;
              min_inc = min_nxt + MIN_W'(1);
              min_nxt = (min_inc >= MIN_WRAP) ? '0 : min_inc;
            end
          end
        end
      end

      default: begin
      end
    endcase

    if (!run_nxt) begin
      led_nxt = alarm_nxt;
    end
    last_nxt = pat;
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (take) begin
      ovalid_nxt = 1'b1;
    end else if (!out_stall) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r    <= '0;
      sec_r    <= '0;
      hun_r    <= '0;
      pre_r    <= '0;
      run_r    <= 1'b0;
      alarm_r  <= 1'b0;
      led_r    <= 1'b0;
      hold_r   <= '0;
      rep_r    <= '0;
      last_r   <= PAT_NONE;
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
      if (take) begin
        min_r   <= min_nxt;
        sec_r   <= sec_nxt;
        hun_r   <= hun_nxt;
        pre_r   <= pre_nxt;
        run_r   <= run_nxt;
        alarm_r <= alarm_nxt;
        led_r   <= led_nxt;
        hold_r  <= hold_nxt;
        rep_r   <= rep_nxt;
        last_r  <= last_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      omin_r   <= min_nxt;
      osec_r   <= sec_nxt;
      ohun_r   <= (cfg.mode == MODE_STOPWATCH) ? hun_nxt : '0;
      orun_r   <= run_nxt;
      oalarm_r <= alarm_nxt;
      oled_r   <= led_nxt;
    end
  end

  assign out_valid      = ovalid_r;
  assign out_minutes    = omin_r;
  assign out_seconds    = osec_r;
  assign out_hundredths = ohun_r;
  assign out_running    = orun_r;
  assign out_alarm      = oalarm_r;
  assign out_led        = oled_r;

endmodule

/* sv/countdown_timer_stopwatch_top.sv */
// ----------------------------------------------------------------------------
// Countdown timer and stopwatch
// One 10 ms tick item with three button levels in, one display item out.
//
//   Port group  Handshake           Payload
//   in_         in_valid/in_stall   in_button_one, in_button_two, in_button_three
//   out_        out_valid/out_stall minutes, seconds, hundredths, running, alarm, led
//   cfg_        cfg_wr_en           cfg_index, cfg_wdata
//
// An accepted item passes through the input register, then through the update
// logic into the result register.
// One item is accepted every cycle while the result side keeps up.
// Reset clears all timer state and loads the register reset values.
// A stalled result register holds its item and stalls the input stage behind it.
// ----------------------------------------------------------------------------
module countdown_timer_stopwatch_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_button_one,
  input  logic                         in_button_two,
  input  logic                         in_button_three,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ctsw_pkg::MIN_W-1:0]   out_minutes,
  output logic [ctsw_pkg::SEC_W-1:0]   out_seconds,
  output logic [ctsw_pkg::HUN_W-1:0]   out_hundredths,
  output logic                         out_running,
  output logic                         out_alarm,
  output logic                         out_led,
  input  logic                         cfg_wr_en,
  input  logic [1:0]                   cfg_index,
  input  logic [ctsw_pkg::CFG_W-1:0]   cfg_wdata
);
  import ctsw_pkg::*;

  cfg_t      cfg_r;
  cfg_t      cfg_nxt;
  btn_item_t item;
  logic      take;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MODE:   cfg_nxt.mode             = mode_t'(cfg_wdata[0]);
        CFG_REPEAT: cfg_nxt.repeat_ticks     = cfg_wdata[REP_W-1:0];
        CFG_LONG:   cfg_nxt.long_press_ticks = cfg_wdata[HOLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode             <= MODE_TIMER;
      cfg_r.repeat_ticks     <= REPEAT_RESET;
      cfg_r.long_press_ticks <= LONG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ctsw_in_stage u_in_stage (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_button_one   (in_button_one),
    .in_button_two   (in_button_two),
    .in_button_three (in_button_three),
    .take            (take),
    .item            (item)
  );

  ctsw_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .item           (item),
    .take           (take),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_minutes    (out_minutes),
    .out_seconds    (out_seconds),
    .out_hundredths (out_hundredths),
    .out_running    (out_running),
    .out_alarm      (out_alarm),
    .out_led        (out_led)
  );

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !item.valid |-> !in_stall)
    else $error("input stalled with an empty input register");

  a_led_shows_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_running) |-> (out_led == out_alarm))
    else $error("stopped timer LED differs from alarm");

  a_time_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_seconds <= SEC_LIMIT && out_minutes < MIN_WRAP))
    else $error("displayed time out of range");

  a_timer_no_hundredths: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && cfg_r.mode == MODE_TIMER) |-> (out_hundredths == '0))
    else $error("hundredths shown in countdown mode");

endmodule

/* dv/countdown_timer_stopwatch_top_tb.sv */
// ----------------------------------------------------------------------------
// Countdown timer and stopwatch testbench
// Drives button tick items through the timer block with random gaps and
// result stalls, predicts every display item with a cycle-free model of the
// timer state, and compares each display item field by field. The run covers
// both modes, every button pattern, repeat and long-press extremes, the alarm
// and a stopwatch carry from the seconds into the minutes.
// ----------------------------------------------------------------------------
module countdown_timer_stopwatch_top_tb;
  import ctsw_pkg::*;

  localparam int unsigned PIPE_LAT    = 2;
  localparam int unsigned PHASE_TICKS = 25;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned QUEUE_DEPTH = 4096;

  typedef struct packed {
    logic [MIN_W-1:0] minutes;
    logic [SEC_W-1:0] seconds;
    logic [HUN_W-1:0] hundredths;
    logic             running;
    logic             alarm;
    logic             led;
  } disp_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_button_one = 1'b0;
  logic              in_button_two = 1'b0;
  logic              in_button_three = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [MIN_W-1:0]  out_minutes;
  logic [SEC_W-1:0]  out_seconds;
  logic [HUN_W-1:0]  out_hundredths;
  logic              out_running;
  logic              out_alarm;
  logic              out_led;
  logic              cfg_wr_en = 1'b0;
  logic [1:0]        cfg_index = CFG_MODE;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  cfg_t              tmr_cfg = '{MODE_TIMER, REPEAT_RESET, LONG_RESET};
  logic [MIN_W-1:0]  cur_min = '0;
  logic [SEC_W-1:0]  cur_sec = '0;
  logic [HUN_W-1:0]  cur_hun = '0;
  logic [PRE_W-1:0]  sec_presc = '0;
  logic              run_f = 1'b0;
  logic              alarm_f = 1'b0;
  logic              led_f = 1'b0;
  logic [HOLD_W-1:0] hold_ticks = '0;
  logic [REP_W-1:0]  rep_ticks = '0;
  logic [2:0]        prev_pat = PAT_NONE;

  logic [2:0]        tick_q[$];
  disp_t             disp_q[$];
  int unsigned       ticks_queued = 0;
  int unsigned       ticks_taken = 0;
  int unsigned       error_cnt = 0;
  int unsigned       in_gap = 0;
  int unsigned       stall_left = 0;
  bit                in_idle_en = 1'b1;
  bit                out_idle_en = 1'b1;
  logic              in_fire = 1'b0;
  logic              out_fire = 1'b0;

  countdown_timer_stopwatch_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_button_one   (in_button_one),
    .in_button_two   (in_button_two),
    .in_button_three (in_button_three),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_minutes     (out_minutes),
    .out_seconds     (out_seconds),
    .out_hundredths  (out_hundredths),
    .out_running     (out_running),
    .out_alarm       (out_alarm),
    .out_led         (out_led),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void bump_setting(logic [2:0] pat);
    if (pat == PAT_ONE) begin
      if (cur_min < SET_LIMIT) cur_min++;
    end else if (cur_sec < SEC_LIMIT) begin
      cur_sec++;
    end
  endfunction

  function automatic disp_t advance_tick(logic [2:0] pat);
    disp_t d;
    if (tmr_cfg.mode == MODE_TIMER) begin
      if ((pat == PAT_ONE || pat == PAT_TWO) && !run_f) begin
        alarm_f = 1'b0;
        if (prev_pat != pat) begin
          bump_setting(pat);
          rep_ticks = '0;
        end else begin
          rep_ticks++;
          if (rep_ticks >= tmr_cfg.repeat_ticks) begin
            bump_setting(pat);
            rep_ticks = '0;
          end
        end
      end else begin
        rep_ticks = '0;
      end
      if (pat == PAT_THREE) begin
        if (hold_ticks < HOLD_MAX) hold_ticks++;
      end else begin
        // The press is judged when the lone button 3 pattern ends.
        if (prev_pat == PAT_THREE) begin
          if (hold_ticks >= tmr_cfg.long_press_ticks) begin
            cur_min = '0;
            cur_sec = '0;
            alarm_f = 1'b0;
            run_f = 1'b0;
          end else if (run_f) begin
            run_f = 1'b0;
          end else if (cur_min != 0 || cur_sec != 0) begin
            run_f = 1'b1;
            alarm_f = 1'b0;
            sec_presc = '0;
            led_f = 1'b0;
          end
        end
        hold_ticks = '0;
      end
      if (run_f) begin
        sec_presc++;
        if (sec_presc >= TICKS_PER_SEC) begin
          sec_presc = '0;
          led_f = !led_f;
          if (cur_sec != 0) begin
            cur_sec--;
          end else if (cur_min != 0) begin
            cur_min--;
            cur_sec = SEC_LIMIT;
          end
          if (cur_min == 0 && cur_sec == 0) begin
            alarm_f = 1'b1;
            run_f = 1'b0;
          end
        end
      end
    end else begin
      rep_ticks = '0;
      hold_ticks = '0;
      if (pat == PAT_ONE && prev_pat != PAT_ONE) begin
        run_f = !run_f;
      end else if (pat == PAT_TWO) begin
        run_f = 1'b0;
        cur_min = '0;
        cur_sec = '0;
        cur_hun = '0;
      end
      if (run_f) begin
        led_f = 1'b1;
        cur_hun++;
        if (cur_hun >= HUN_WRAP) begin
          cur_hun = '0;
          cur_sec++;
          if (cur_sec >= SEC_WRAP) begin
            cur_sec = '0;
            cur_min++;
            if (cur_min >= MIN_WRAP) cur_min = '0;
          end
        end
      end
    end
    if (!run_f) led_f = alarm_f;
    prev_pat = pat;
    d.minutes = cur_min;
    d.seconds = cur_sec;
    d.hundredths = (tmr_cfg.mode == MODE_STOPWATCH) ? cur_hun : '0;
    d.running = run_f;
    d.alarm = alarm_f;
    d.led = led_f;
    return d;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_cnt++;
    end
  endtask

  always @(posedge clk) begin
    disp_t want;
    in_fire <= rst_n && in_valid && !in_stall;
    out_fire <= rst_n && out_valid && !out_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (disp_q.size() == 0) begin
        $error("display item arrived with no item expected");
        error_cnt++;
      end else begin
        want = disp_q.pop_front();
        check_field("minutes", want.minutes, out_minutes);
        check_field("seconds", want.seconds, out_seconds);
        check_field("hundredths", want.hundredths, out_hundredths);
        check_field("running", want.running, out_running);
        check_field("alarm", want.alarm, out_alarm);
        check_field("led", want.led, out_led);
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      disp_q.push_back(advance_tick({in_button_three, in_button_two, in_button_one}));
      ticks_taken++;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (tick_q.size() != 0) begin
        {in_button_three, in_button_two, in_button_one} <= tick_q.pop_front();
        in_valid <= 1'b1;
        in_gap = in_idle_en ? $urandom_range(0, 5) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (out_fire) stall_left = out_idle_en ? $urandom_range(0, 5) : 0;
    if (rst_n && out_valid && stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic queue_ticks(logic [2:0] pat, int unsigned n);
    repeat (n) begin
      while (tick_q.size() >= QUEUE_DEPTH) @(negedge clk);
      tick_q.push_back(pat);
      ticks_queued++;
    end
  endtask

  task automatic press(logic [2:0] pat, int unsigned n);
    queue_ticks(pat, n);
    queue_ticks(PAT_NONE, 1);
  endtask

  task automatic noise();
    repeat ($urandom_range(1, 4)) queue_ticks(3'($urandom_range(0, 7)), 1);
  endtask

  function automatic int unsigned short_hold();
    if (tmr_cfg.long_press_ticks <= 1) return 1;
    if (tmr_cfg.long_press_ticks > 13) return $urandom_range(1, 12);
    return $urandom_range(1, tmr_cfg.long_press_ticks - 1);
  endfunction

  task automatic drain_results();
    while (ticks_taken != ticks_queued || disp_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_MODE:   tmr_cfg.mode = mode_t'(val[0]);
      CFG_REPEAT: tmr_cfg.repeat_ticks = val[REP_W-1:0];
      CFG_LONG:   tmr_cfg.long_press_ticks = val[HOLD_W-1:0];
      default: begin
      end
    endcase
  endtask

  task automatic apply_settings(mode_t m, int unsigned rep, int unsigned lng);
    drain_results();
    repeat (PIPE_LAT) @(negedge clk);
    write_reg(CFG_MODE, CFG_W'(m));
    write_reg(CFG_REPEAT, CFG_W'(rep));
    write_reg(CFG_LONG, CFG_W'(lng));
  endtask

  task automatic timer_sequence();
    int unsigned len;
    logic [2:0] adj;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        adj = $urandom_range(0, 1) ? PAT_ONE : PAT_TWO;
        if (tmr_cfg.repeat_ticks < 40) len = $urandom_range(1, 2 * tmr_cfg.repeat_ticks + 3);
        else len = $urandom_range(1, tmr_cfg.repeat_ticks + 10);
        press(adj, len);
      end
      3, 4: press(PAT_THREE, short_hold());
      5: begin
        len = tmr_cfg.long_press_ticks + $urandom_range(0, 2);
        press(PAT_THREE, (len == 0) ? 1 : len);
      end
      6: queue_ticks(PAT_NONE, $urandom_range(1, 40));
      7: noise();
      8: begin
        // Clear the count, set one second, start it and let it count down toward the alarm.
        press(PAT_THREE, tmr_cfg.long_press_ticks + 1);
        press(PAT_TWO, 1);
        press(PAT_THREE, short_hold());
        queue_ticks(PAT_NONE, $urandom_range(95, 140));
      end
      default: begin
        queue_ticks(PAT_ONE, $urandom_range(1, 5));
        press(PAT_TWO, $urandom_range(1, 5));
      end
    endcase
  endtask

  task automatic watch_sequence();
    case ($urandom_range(0, 9))
      0, 1, 2: press(PAT_ONE, $urandom_range(1, 3));
      3:       press(PAT_TWO, $urandom_range(1, 2));
      4, 5, 6: queue_ticks(PAT_NONE, $urandom_range(1, 150));
      7:       noise();
      8:       press(PAT_THREE, $urandom_range(1, 5));
      default: press(PAT_ONE, $urandom_range(4, 30));
    endcase
  endtask

  task automatic run_phase(mode_t m, int unsigned rep, int unsigned lng, bit gap_en,
                           bit stall_en);
    int unsigned start;
    apply_settings(m, rep, lng);
    in_idle_en = gap_en;
    out_idle_en = stall_en;
    start = ticks_queued;
    while (ticks_queued - start < PHASE_TICKS) begin
      if (m == MODE_TIMER) timer_sequence();
      else watch_sequence();
    end
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_ticks(PAT_NONE, 1);
    press(PAT_ONE, 1);
    press(PAT_TWO, 2);
    queue_ticks(PAT_ONE | PAT_TWO, 1);
    queue_ticks(PAT_ONE | PAT_THREE, 1);
    queue_ticks(PAT_TWO | PAT_THREE, 1);
    queue_ticks(PAT_ONE | PAT_TWO | PAT_THREE, 1);
    press(PAT_THREE, 1);
    queue_ticks(PAT_ONE, 1);
    queue_ticks(PAT_TWO, 1);
    press(PAT_THREE, 1);
    press(PAT_THREE, 1);
    queue_ticks(PAT_NONE, 3);
    press(PAT_THREE, 1);

    run_phase(MODE_TIMER, REPEAT_RESET, 12, 1'b1, 1'b1);
    run_phase(MODE_TIMER, 1, 1, 1'b1, 1'b0);
    run_phase(MODE_TIMER, 0, 0, 1'b0, 1'b1);
    run_phase(MODE_STOPWATCH, 7, 5, 1'b0, 1'b0);
    run_phase(MODE_TIMER, 255, 30, 1'b1, 1'b1);
    run_phase(MODE_STOPWATCH, $urandom_range(1, 255), $urandom_range(1, 1023), 1'b1, 1'b1);
    run_phase(MODE_TIMER, $urandom_range(2, 30), $urandom_range(2, 40), 1'b1, 1'b0);
    run_phase(MODE_STOPWATCH, $urandom_range(0, 255), $urandom_range(0, 1023), 1'b0, 1'b1);
    run_phase(MODE_TIMER, $urandom_range(0, 255), $urandom_range(0, 60), 1'b1, 1'b1);

    // Set 00:59 in timer mode, then let the stopwatch carry into the minutes.
    apply_settings(MODE_TIMER, 1, 2);
    in_idle_en = 1'b0;
    out_idle_en = 1'b0;
    press(PAT_THREE, 3);
    press(PAT_TWO, 59);
    apply_settings(MODE_STOPWATCH, 1, 2);
    press(PAT_ONE, 1);
    queue_ticks(PAT_NONE, 110);
    press(PAT_ONE, 1);
    press(PAT_TWO, 1);

    drain_results();
    repeat (PIPE_LAT + 2) @(posedge clk);
    if (error_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
